### src/mmf_pkg.sv
// shared types, codes and single precision helpers for the matrix multiply unit
// used by the controller, the datapath and both floating point units
package mmf_pkg;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 2'd2;

  localparam logic [1:0] MODE_WR_A = 2'd0;
  localparam logic [1:0] MODE_WR_B = 2'd1;
  localparam logic [1:0] MODE_RD_C = 2'd2;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  localparam int DEF_MAX_ROWS  = 64;
  localparam int DEF_MAX_INNER = 64;
  localparam int DEF_MAX_COLS  = 64;

  // cycles between two dot product steps, minus one
  localparam logic [2:0] ISSUE_GAP = 3'd4;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  typedef enum logic [1:0] {FK_NUM, FK_ZERO, FK_INF, FK_NAN} fpk_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             start;
    logic             issue;
    logic [CFG_W-1:0] k;
    logic             load_out;
    logic             err;
  } mmf_cmd_t;

  typedef struct packed {
    logic add_done;
  } mmf_stat_t;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // sig has its leading one at bit 47, ex is the biased exponent of that bit
  function automatic logic [31:0] fp_pack(input logic sgn, input logic signed [11:0] ex,
                                          input logic [47:0] sig);
    logic [11:0] amt;
    logic [10:0] e1;
    logic [47:0] sh;
    logic        lost;
    logic [23:0] m24;
    logic        up;
    logic [34:0] total;
    if (ex < 12'sd1) begin
      amt = 12'(12'sd1 - ex);
      e1  = '0;
    end else begin
      amt = '0;
      e1  = 11'(ex - 12'sd1);
    end
    sh    = sig >> amt;
    lost  = |(sig & ~({48{1'b1}} << amt));
    m24   = sh[47:24];
    up    = sh[23] & ((|sh[22:0]) | lost | m24[0]);
    // rounding carry walks into the exponent field by itself
    total = {1'b0, e1, 23'b0} + 35'(m24) + 35'(up);
    if (total >= 35'h0_7F80_0000) return {sgn, 8'hFF, 23'h0};
    return {sgn, total[30:0]};
  endfunction

  function automatic logic [31:0] fp_result(input fpk_t kind, input logic sgn,
                                            input logic signed [11:0] ex,
                                            input logic [47:0] sig);
    logic [31:0] r;
    case (kind)
      FK_NUM:  r = fp_pack(sgn, ex, sig);
      FK_ZERO: r = {sgn, 31'h0};
      FK_INF:  r = {sgn, 8'hFF, 23'h0};
      default: r = QNAN;
    endcase
    return r;
  endfunction

endpackage

### src/mmf_fpmul.sv
// three stage single precision multiplier, round to nearest even
// depends on mmf_pkg for the lead zero count and packing
module mmf_fpmul (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] y
);

  logic        a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic [23:0] ma, mb;
  logic [11:0] ea, eb;
  mmf_pkg::fpk_t kind0;

  logic                v1, v2;
  logic [47:0]         s1_p, s2_sig;
  logic signed [11:0]  s1_ex, s2_ex;
  logic                s1_sgn, s2_sgn;
  mmf_pkg::fpk_t       s1_kind, s2_kind;
  logic [5:0]          lz;

  always_comb begin
    a_zero = a[30:0] == 31'h0;
    b_zero = b[30:0] == 31'h0;
    a_inf  = a[30:23] == 8'hFF && a[22:0] == 23'h0;
    b_inf  = b[30:23] == 8'hFF && b[22:0] == 23'h0;
    a_nan  = a[30:23] == 8'hFF && a[22:0] != 23'h0;
    b_nan  = b[30:23] == 8'hFF && b[22:0] != 23'h0;
    ma     = {a[30:23] != 8'h0, a[22:0]};
    mb     = {b[30:23] != 8'h0, b[22:0]};
    ea     = (a[30:23] == 8'h0) ? 12'd1 : 12'(a[30:23]);
    eb     = (b[30:23] == 8'h0) ? 12'd1 : 12'(b[30:23]);
    if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) kind0 = mmf_pkg::FK_NAN;
    else if (a_inf || b_inf)   kind0 = mmf_pkg::FK_INF;
    else if (a_zero || b_zero) kind0 = mmf_pkg::FK_ZERO;
    else                       kind0 = mmf_pkg::FK_NUM;
    lz = mmf_pkg::lzc48(s1_p);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
    s1_p    <= ma * mb;
    s1_ex   <= $signed(ea + eb) - 12'sd126;
    s1_sgn  <= a[31] ^ b[31];
    s1_kind <= kind0;
    s2_sig  <= s1_p << lz;
    s2_ex   <= s1_ex - $signed({6'b0, lz});
    s2_sgn  <= s1_sgn;
    s2_kind <= s1_kind;
    y       <= mmf_pkg::fp_result(s2_kind, s2_sgn, s2_ex, s2_sig);
  end

endmodule

### src/mmf_fpadd.sv
// four stage single precision adder, round to nearest even
// depends on mmf_pkg for the lead zero count and packing
module mmf_fpadd (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        out_valid,
  output logic [31:0] y
);

  logic        a_inf, b_inf, a_nan, b_nan, a_big;
  logic [31:0] big, sml;
  logic [7:0]  e_big, e_sml;
  mmf_pkg::fpk_t kind0;

  logic               v1, v2, v3;
  mmf_pkg::fpk_t      k1, k2, k3;
  logic               sg1, sg2, sg3, zs1, zs2, sub1;
  logic [23:0]        mb1, ms1;
  logic [7:0]         d1;
  logic signed [11:0] ex1, ex2, ex3;
  logic [27:0]        sum2;
  logic [47:0]        sig3;

  logic [26:0] sx, sh;
  logic        lost;
  logic [27:0] bigx, al;
  logic [47:0] wide;
  logic [5:0]  lz;

  always_comb begin
    a_inf = a[30:23] == 8'hFF && a[22:0] == 23'h0;
    b_inf = b[30:23] == 8'hFF && b[22:0] == 23'h0;
    a_nan = a[30:23] == 8'hFF && a[22:0] != 23'h0;
    b_nan = b[30:23] == 8'hFF && b[22:0] != 23'h0;
    // bit patterns order like magnitudes
    a_big = a[30:0] >= b[30:0];
    big   = a_big ? a : b;
    sml   = a_big ? b : a;
    e_big = (big[30:23] == 8'h0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'h0) ? 8'd1 : sml[30:23];
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) kind0 = mmf_pkg::FK_NAN;
    else if (a_inf || b_inf) kind0 = mmf_pkg::FK_INF;
    else                     kind0 = mmf_pkg::FK_NUM;

    sx   = {ms1, 3'b0};
    sh   = sx >> d1;
    lost = |(sx & ~({27{1'b1}} << d1));
    al   = {1'b0, sh[26:1], sh[0] | lost};
    bigx = {1'b0, mb1, 3'b0};

    wide = {sum2, 20'b0};
    lz   = mmf_pkg::lzc48(wide);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
    k1   <= kind0;
    sg1  <= big[31];
    zs1  <= a[31] & b[31];
    sub1 <= a[31] ^ b[31];
    mb1  <= {big[30:23] != 8'h0, big[22:0]};
    ms1  <= {sml[30:23] != 8'h0, sml[22:0]};
    d1   <= e_big - e_sml;
    ex1  <= $signed(12'(e_big)) + 12'sd1;

    k2   <= k1;
    sg2  <= sg1;
    zs2  <= zs1;
    ex2  <= ex1;
    sum2 <= sub1 ? bigx - al : bigx + al;

    // exact cancellation gives +0 unless both inputs were -0
    if (k2 == mmf_pkg::FK_NUM && sum2 == 28'h0) begin
      k3  <= mmf_pkg::FK_ZERO;
      sg3 <= zs2;
    end else begin
      k3  <= k2;
      sg3 <= sg2;
    end
    sig3 <= wide << lz;
    ex3  <= ex2 - $signed({6'b0, lz});

    y <= mmf_pkg::fp_result(k3, sg3, ex3, sig3);
  end

endmodule

### src/mmf_datapath.sv
// element stores, operand fetch, multiply and accumulate, result register
// depends on mmf_pkg, mmf_fpmul and mmf_fpadd
module mmf_datapath #(
  parameter int MAX_ROWS  = mmf_pkg::DEF_MAX_ROWS,
  parameter int MAX_INNER = mmf_pkg::DEF_MAX_INNER,
  parameter int MAX_COLS  = mmf_pkg::DEF_MAX_COLS
) (
  input  logic                clk,
  input  logic                rst,
  input  mmf_pkg::mmf_cmd_t   cmd,
  input  logic [5:0]          row,
  input  logic [5:0]          col,
  input  logic [31:0]         value,
  output mmf_pkg::mmf_stat_t  stat,
  output logic [31:0]         product
);

  localparam int DA   = MAX_ROWS * MAX_INNER;
  localparam int DB   = MAX_INNER * MAX_COLS;
  localparam int AW_A = (DA > 1) ? $clog2(DA) : 1;
  localparam int AW_B = (DB > 1) ? $clog2(DB) : 1;

  logic [31:0] a_mem [DA];
  logic [31:0] b_mem [DB];

  logic [AW_A-1:0] wa_addr, ra_addr;
  logic [AW_B-1:0] wb_addr, rb_addr;
  logic [5:0]      i_reg, j_reg;
  logic [31:0]     a_rd, b_rd, acc, mul_y, add_y;
  logic            rd_vld, mul_vld, add_vld;

  assign wa_addr = AW_A'(row) * AW_A'(MAX_INNER) + AW_A'(col);
  assign wb_addr = AW_B'(row) * AW_B'(MAX_COLS) + AW_B'(col);
  assign ra_addr = AW_A'(i_reg) * AW_A'(MAX_INNER) + AW_A'(cmd.k);
  assign rb_addr = AW_B'(cmd.k) * AW_B'(MAX_COLS) + AW_B'(j_reg);

  always_ff @(posedge clk) begin
    if (cmd.wr_a) a_mem[wa_addr] <= value;
    if (cmd.issue) a_rd <= a_mem[ra_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) b_mem[wb_addr] <= value;
    if (cmd.issue) b_rd <= b_mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.issue;
    end
    if (cmd.start) begin
      i_reg <= row;
      j_reg <= col;
      acc   <= 32'h0;
    end else if (add_vld) begin
      acc <= add_y;
    end
    if (cmd.load_out) product <= cmd.err ? 32'h0 : acc;
  end

  mmf_fpmul u_mul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rd_vld),
    .a        (a_rd),
    .b        (b_rd),
    .out_valid(mul_vld),
    .y        (mul_y)
  );

  mmf_fpadd u_add (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mul_vld),
    .a        (acc),
    .b        (mul_y),
    .out_valid(add_vld),
    .y        (add_y)
  );

  assign stat.add_done = add_vld;

endmodule

### src/mmf_ctrl.sv
// controller: size registers, range checks, step sequencing, output valid
// depends on mmf_pkg
module mmf_ctrl #(
  parameter int MAX_ROWS  = mmf_pkg::DEF_MAX_ROWS,
  parameter int MAX_INNER = mmf_pkg::DEF_MAX_INNER,
  parameter int MAX_COLS  = mmf_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [5:0]                    row,
  input  logic [5:0]                    col,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output mmf_pkg::mmf_cmd_t             cmd,
  input  mmf_pkg::mmf_stat_t            stat
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  state_t                      state;
  logic [mmf_pkg::CFG_W-1:0]   rows_m, inner_k, cols_n, kk, issued, done_cnt;
  logic [2:0]                  gap;
  logic                        err;
  logic                        accept, row_m, row_k, col_k, col_n;

  assign in_stall = state != ST_IDLE;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    kk    = (32'(inner_k) > MAX_INNER) ? mmf_pkg::CFG_W'(MAX_INNER) : inner_k;
    row_m = (7'(row) < rows_m) && (32'(row) < MAX_ROWS);
    row_k = 7'(row) < kk;
    col_k = 7'(col) < kk;
    col_n = (7'(col) < cols_n) && (32'(col) < MAX_COLS);

    cmd     = '0;
    cmd.k   = issued;
    cmd.err = err;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            mmf_pkg::MODE_WR_A: cmd.wr_a  = row_m && col_k;
            mmf_pkg::MODE_WR_B: cmd.wr_b  = row_k && col_n;
            mmf_pkg::MODE_RD_C: cmd.start = row_m && col_n;
            default: ;
          endcase
        end
      end
      ST_RUN:  cmd.issue    = (gap == 3'd0) && (issued < kk);
      ST_DONE: cmd.load_out = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rows_m    <= mmf_pkg::SIZE_RESET;
      inner_k   <= mmf_pkg::SIZE_RESET;
      cols_n    <= mmf_pkg::SIZE_RESET;
      issued    <= '0;
      done_cnt  <= '0;
      gap       <= '0;
      err       <= 1'b0;
      out_valid <= 1'b0;
      status    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mmf_pkg::CFG_ROWS_M:  rows_m  <= cfg_data;
          mmf_pkg::CFG_INNER_K: inner_k <= cfg_data;
          mmf_pkg::CFG_COLS_N:  cols_n  <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
        status    <= err;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept && mode == mmf_pkg::MODE_RD_C) begin
            err      <= !(row_m && col_n);
            issued   <= '0;
            done_cnt <= '0;
            gap      <= '0;
            state    <= (row_m && col_n && kk != '0) ? ST_RUN : ST_DONE;
          end
        end
        ST_RUN: begin
          if (cmd.issue) begin
            issued <= issued + 1'b1;
            gap    <= mmf_pkg::ISSUE_GAP;
          end else if (gap != 3'd0) begin
            gap <= gap - 1'b1;
          end
          if (stat.add_done) begin
            done_cnt <= done_cnt + 1'b1;
            if (done_cnt == kk - 1'b1) state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (cmd.load_out) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/matrix_multiply_fp32_unit.sv
// top level of the single precision matrix multiply unit
// depends on mmf_pkg, mmf_ctrl and mmf_datapath
//
// input channel (in_valid / in_stall): mode, row, col, value. mode 0 writes
// A[row][col], mode 1 writes B[row][col], mode 2 asks for C[row][col].
// writes give no result; writes outside the sizes are dropped.
// a read walks k = 0 .. inner_k-1: one operand fetch per step from both stores,
// then a 3 stage multiplier and a 4 stage adder whose sum feeds back into the
// accumulator; steps are spaced by ISSUE_GAP so that each product reaches the adder
// just as the previous sum lands in the accumulator. a read outside the sizes, or
// with inner_k zero, runs no steps. in_stall is high after the read beat until the
// result sits in the output register.
// output channel (out_valid / out_stall): product, status. the result is held
// in an output register while the receiver stalls; writes are still taken then,
// and a following read computes but waits to load its result.
// cfg_write / cfg_index / cfg_data set rows_m, inner_k, cols_n (reset 64 each).
// synchronous reset clears the control state and sets the sizes to 64; the stores
// are not cleared and must be written before they are read.
module matrix_multiply_fp32_unit #(
  parameter int MAX_ROWS  = mmf_pkg::DEF_MAX_ROWS,
  parameter int MAX_INNER = mmf_pkg::DEF_MAX_INNER,
  parameter int MAX_COLS  = mmf_pkg::DEF_MAX_COLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mmf_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [5:0]                    row,
  input  logic [5:0]                    col,
  input  logic [31:0]                   value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [31:0]                   product,
  output logic                          status
);

  mmf_pkg::mmf_cmd_t  cmd;
  mmf_pkg::mmf_stat_t stat;

  mmf_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_INNER(MAX_INNER),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .row      (row),
    .col      (col),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd),
    .stat     (stat)
  );

  mmf_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_INNER(MAX_INNER),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .row    (row),
    .col    (col),
    .value  (value),
    .stat   (stat),
    .product(product)
  );

  // a started read keeps the input side closed
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> in_stall)
    else $error("read started but input not stalled");

  // sums only come back while a read is in progress
  a_add_busy: assert property (@(posedge clk) disable iff (rst)
    stat.add_done |-> in_stall)
    else $error("adder result while idle");

  // a loaded result is presented, and an error result carries zero
  a_load_out: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid && (!status || product == 32'h0))
    else $error("bad result load");

endmodule

### verif/tb_top.sv
// self-checking testbench for matrix_multiply_fp32_unit: a bit-exact single precision
// dot product predictor, directed and random A/B writes and C reads with random idling
// depends on mmf_pkg and the matrix_multiply_fp32_unit RTL
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE = 5 * 64 + 30;
  localparam longint LIMIT = 3_000_000;

  typedef struct packed {
    logic [31:0] product;
    logic        status;
  } c_elem_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [mmf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mmf_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [1:0]                    mode = '0;
  logic [5:0]                    row = '0;
  logic [5:0]                    col = '0;
  logic [31:0]                   value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [31:0]                   product;
  logic                          status;

  matrix_multiply_fp32_unit DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] a_mat [0:4095];
  logic [31:0] b_mat [0:4095];
  bit          a_set [0:4095];
  bit          b_set [0:4095];
  logic [6:0]  rows_m = mmf_pkg::SIZE_RESET;
  logic [6:0]  inner_k = mmf_pkg::SIZE_RESET;
  logic [6:0]  cols_n = mmf_pkg::SIZE_RESET;
  c_elem_t     c_expected [$];
  int          fails = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  longint      cycles = 0;

  function automatic int eff(input logic [6:0] r);
    return (r > 64) ? 64 : int'(r);
  endfunction

  // ---------------- single precision arithmetic, round to nearest even ----------------
  function automatic bit is_nan(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 0;
  endfunction

  function automatic bit is_inf(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] == 0;
  endfunction

  function automatic bit is_zero(input logic [31:0] x);
    return x[30:0] == 0;
  endfunction

  // value = sig * 2^ex
  function automatic void split(input logic [31:0] x, output logic [127:0] sig,
                                output int ex);
    if (x[30:23] == 0) begin
      sig = 128'(x[22:0]);
      ex = -149;
    end else begin
      sig = 128'({1'b1, x[22:0]});
      ex = int'(x[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] fp_round(input logic sgn, input logic [127:0] m,
                                           input int e);
    int p;
    int lsb;
    int sh;
    int bexp;
    logic [127:0] q;
    logic rb;
    logic st;
    p = -1;
    for (int i = 0; i < 128; i++) if (m[i]) p = i;
    if (p < 0) return {sgn, 31'h0};
    lsb = e + p - 23;
    if (lsb < -149) lsb = -149;
    sh = lsb - e;
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh > p + 1) begin
      return {sgn, 31'h0};
    end else begin
      q = m >> sh;
      rb = m[sh-1];
      st = |(m & ((128'b1 << (sh - 1)) - 128'b1));
      if (rb && (st || q[0])) q = q + 128'b1;
    end
    if (q[24]) begin
      q = q >> 1;
      lsb++;
    end
    if (q == 0) return {sgn, 31'h0};
    if (!q[23]) return {sgn, 8'h00, q[22:0]};
    bexp = lsb + 150;
    if (bexp >= 255) return {sgn, 8'hFF, 23'h0};
    return {sgn, 8'(bexp), q[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic sgn;
    logic [127:0] ma;
    logic [127:0] mb;
    int ea;
    int eb;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return mmf_pkg::QNAN;
    if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b))) return mmf_pkg::QNAN;
    if (is_inf(a) || is_inf(b)) return {sgn, 8'hFF, 23'h0};
    if (is_zero(a) || is_zero(b)) return {sgn, 31'h0};
    split(a, ma, ea);
    split(b, mb, eb);
    return fp_round(sgn, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    int ea;
    int eb;
    int e;
    if (is_nan(a) || is_nan(b)) return mmf_pkg::QNAN;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return mmf_pkg::QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'h0};
    if (is_zero(a)) return b;
    if (is_zero(b)) return a;
    split(a, ma, ea);
    split(b, mb, eb);
    // a far smaller operand only matters as a sticky bit
    if (ea - eb > 50) begin
      e = ea - 50;
      ma = ma << 50;
      mb = 128'b1;
    end else if (eb - ea > 50) begin
      e = eb - 50;
      mb = mb << 50;
      ma = 128'b1;
    end else begin
      e = (ea < eb) ? ea : eb;
      ma = ma << (ea - e);
      mb = mb << (eb - e);
    end
    if (a[31] == b[31]) return fp_round(a[31], ma + mb, e);
    if (ma == mb) return 32'h0;
    if (ma > mb) return fp_round(a[31], ma - mb, e);
    return fp_round(b[31], mb - ma, e);
  endfunction

  function automatic logic [31:0] dot_c(input int i, input int j, input int kk);
    logic [31:0] acc;
    acc = 32'h0;
    for (int k = 0; k < kk; k++) acc = fp_add(acc, fp_mul(a_mat[i*64+k], b_mat[k*64+j]));
    return is_nan(acc) ? mmf_pkg::QNAN : acc;
  endfunction

  function automatic bit readable(input int i, input int j);
    if (i >= eff(rows_m) || j >= eff(cols_n)) return 1'b1;
    for (int k = 0; k < eff(inner_k); k++)
      if (!a_set[i*64+k] || !b_set[k*64+j]) return 1'b0;
    return 1'b1;
  endfunction

  // update the stores and queue the C element that an accepted beat causes
  function automatic void predict_beat(input logic [1:0] md, input int r, input int c,
                                       input logic [31:0] v);
    c_elem_t res;
    case (md)
      mmf_pkg::MODE_WR_A: if (r < eff(rows_m) && c < eff(inner_k)) begin
        a_mat[r*64+c] = v;
        a_set[r*64+c] = 1'b1;
      end
      mmf_pkg::MODE_WR_B: if (r < eff(inner_k) && c < eff(cols_n)) begin
        b_mat[r*64+c] = v;
        b_set[r*64+c] = 1'b1;
      end
      mmf_pkg::MODE_RD_C: begin
        if (r < eff(rows_m) && c < eff(cols_n)) begin
          res.product = dot_c(r, c, eff(inner_k));
          res.status = 1'b0;
        end else begin
          res.product = 32'h0;
          res.status = 1'b1;
        end
        c_expected = {c_expected, res};
      end
      default: ;
    endcase
  endfunction

  // ---------------- drivers ----------------
  task automatic send_beat(input logic [1:0] md, input int r, input int c,
                           input logic [31:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= md;
    row <= 6'(r);
    col <= 6'(c);
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(md, r, c, v);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (c_expected.size() != 0) @(posedge clk);
  endtask

  task automatic set_size(input logic [mmf_pkg::CFG_IDX_W-1:0] idx, input logic [6:0] v);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      mmf_pkg::CFG_ROWS_M:  rows_m = v;
      mmf_pkg::CFG_INNER_K: inner_k = v;
      default:              cols_n = v;
    endcase
  endtask

  task automatic set_sizes(input logic [6:0] m, input logic [6:0] k, input logic [6:0] n);
    set_size(mmf_pkg::CFG_ROWS_M, m);
    set_size(mmf_pkg::CFG_INNER_K, k);
    set_size(mmf_pkg::CFG_COLS_N, n);
  endtask

  function automatic logic [31:0] rand_fp();
    logic [31:0] odd [0:10];
    odd = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
            32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'h0080_0000,
            32'h3F80_0000};
    case ($urandom_range(9))
      0, 1, 2, 3: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
      4:          return odd[$urandom_range(10)];
      5:          return {1'($urandom), 8'h00, 23'($urandom)};
      6:          return {1'($urandom), 8'($urandom_range(1, 20)), 23'($urandom)};
      7:          return {1'($urandom), 8'($urandom_range(235, 254)), 23'($urandom)};
      default:    return $urandom;
    endcase
  endfunction

  // write every A and B element inside the current sizes
  task automatic fill_stores();
    for (int i = 0; i < eff(rows_m); i++)
      for (int k = 0; k < eff(inner_k); k++) send_beat(mmf_pkg::MODE_WR_A, i, k, rand_fp());
    for (int k = 0; k < eff(inner_k); k++)
      for (int j = 0; j < eff(cols_n); j++) send_beat(mmf_pkg::MODE_WR_B, k, j, rand_fp());
  endtask

  // ---------------- checker ----------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (out_valid && !out_stall) begin
        if (c_expected.size() == 0) begin
          $error("result beat with nothing expected: product %h status %0d", product, status);
          fails++;
        end else begin
          c_elem_t exp_c;
          exp_c = c_expected.pop_front();
          if (product !== exp_c.product) begin
            $error("product: expected %h actual %h", exp_c.product, product);
            fails++;
          end
          if (status !== exp_c.status) begin
            $error("status: expected %0d actual %0d", exp_c.status, status);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("matrix_multiply_fp32_unit verification failed");
      $finish;
    end
  end

  // ---------------- tests ----------------
  // reset sizes: one full 64 long dot product
  task automatic test_reset_sizes();
    for (int k = 0; k < 64; k++) send_beat(mmf_pkg::MODE_WR_A, 0, k, rand_fp());
    for (int k = 0; k < 64; k++)
      send_beat(mmf_pkg::MODE_WR_B, k, 0,
                {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)});
    send_beat(mmf_pkg::MODE_RD_C, 0, 0, 32'hFFFF_FFFF);
  endtask

  // infinities, overflow, zero times infinity, denormals, range errors, unused mode
  task automatic test_special_values();
    set_sizes(7'd2, 7'd2, 7'd2);
    send_beat(mmf_pkg::MODE_WR_A, 0, 0, 32'h7F80_0000);
    send_beat(mmf_pkg::MODE_WR_A, 0, 1, 32'h3F80_0000);
    send_beat(mmf_pkg::MODE_WR_A, 1, 0, 32'h7F7F_FFFF);
    send_beat(mmf_pkg::MODE_WR_A, 1, 1, 32'h7F7F_FFFF);
    send_beat(mmf_pkg::MODE_WR_B, 0, 0, 32'h0000_0000);
    send_beat(mmf_pkg::MODE_WR_B, 0, 1, 32'h4000_0000);
    send_beat(mmf_pkg::MODE_WR_B, 1, 0, 32'h4000_0000);
    send_beat(mmf_pkg::MODE_WR_B, 1, 1, 32'h0000_0001);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) send_beat(mmf_pkg::MODE_RD_C, i, j, 32'h0);
    send_beat(mmf_pkg::MODE_RD_C, 2, 0, 32'h0);
    send_beat(mmf_pkg::MODE_RD_C, 0, 63, 32'h0);
    send_beat(mmf_pkg::MODE_WR_A, 5, 5, 32'h1234_5678);
    send_beat(MODE_UNUSED, 0, 0, 32'hFFFF_FFFF);
    send_beat(mmf_pkg::MODE_WR_B, 1, 1, 32'h8000_0001);
    send_beat(mmf_pkg::MODE_RD_C, 1, 1, 32'h0);
  endtask

  // zero sizes and sizes above the maximum
  task automatic test_size_extremes();
    set_size(mmf_pkg::CFG_INNER_K, 7'd0);
    send_beat(mmf_pkg::MODE_WR_A, 0, 0, 32'h3F80_0000);
    send_beat(mmf_pkg::MODE_RD_C, 0, 0, 32'h0);
    set_size(mmf_pkg::CFG_ROWS_M, 7'd0);
    send_beat(mmf_pkg::MODE_RD_C, 0, 0, 32'h0);
    set_sizes(7'd127, 7'd1, 7'd127);
    send_beat(mmf_pkg::MODE_WR_A, 63, 0, rand_fp());
    send_beat(mmf_pkg::MODE_WR_B, 0, 63, rand_fp());
    send_beat(mmf_pkg::MODE_RD_C, 63, 63, 32'h0);
    set_size(mmf_pkg::CFG_COLS_N, 7'd0);
    send_beat(mmf_pkg::MODE_RD_C, 0, 0, 32'h0);
  endtask

  task automatic test_random(input int sp, input int rp);
    int i;
    int j;
    int pick;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int c = 0; c < 3; c++) begin
      set_sizes(7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)));
      fill_stores();
      if (c == 1) wait_drained();
      for (int t = 0; t < 30; t++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          if ($urandom_range(3) == 0) begin
            i = $urandom_range(63);
            j = $urandom_range(63);
          end else begin
            i = $urandom_range(eff(rows_m) - 1);
            j = $urandom_range(eff(cols_n) - 1);
          end
          if (readable(i, j)) send_beat(mmf_pkg::MODE_RD_C, i, j, $urandom);
        end else if (pick < 85) begin
          if ($urandom_range(1)) begin
            i = $urandom_range(63);
            j = $urandom_range(63);
          end else begin
            i = $urandom_range(3);
            j = $urandom_range(3);
          end
          send_beat($urandom_range(1) ? mmf_pkg::MODE_WR_A : mmf_pkg::MODE_WR_B, i, j,
                    rand_fp());
        end else begin
          send_beat(MODE_UNUSED, $urandom_range(63), $urandom_range(63), $urandom);
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_sizes();
    test_special_values();
    test_size_extremes();
    test_random(25, 74);
    test_random(74, 25);
    test_random(0, 0);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (c_expected.size() != 0) begin
      $error("%0d results never arrived", c_expected.size());
      fails++;
    end
    if (fails == 0) begin
      $display("matrix_multiply_fp32_unit verification clean");
    end else begin
      $display("matrix_multiply_fp32_unit verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/mmf_pkg.sv
src/mmf_fpmul.sv
src/mmf_fpadd.sv
src/mmf_datapath.sv
src/mmf_ctrl.sv
src/matrix_multiply_fp32_unit.sv
verif/tb_top.sv
